[rtl/sro_pkg.sv]
`timescale 1ns / 1ps

package sro_pkg;

  localparam int SeqW              = 32;
  localparam int HandleW           = 16;
  localparam int SroWindow         = 32;
  localparam int SroHandleBits     = 16;

  typedef enum logic [1:0] {
    ST_DELIVERED = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_HELD      = 2'd2,
    ST_BEYOND    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_ADV,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic [SeqW-1:0]    seq_number;
    logic [HandleW-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [HandleW-1:0] out_handle;
    logic [SeqW-1:0]    out_seq_number;
    status_t            status;
    logic               last;
  } out_item_t;

endpackage

[rtl/sro_slot_mem.sv]
`timescale 1ns / 1ps

module sro_slot_mem #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/sequence_reorder_buffer_unit.sv]
`timescale 1ns / 1ps
// Channel   Ports                         Handshake
// input     in_item (seq_number, handle)  taken when start && !busy
// result    out_item (handle, seq, ...)   out_valid strobe, one cycle each
//
// Out-of-order, duplicate and beyond-window items: one result each.
// In-order item: its own result first, then one result
// per drained held entry (one slot memory read per cycle, 32-bit adder shared
// between the distance check and the expected-number increment).
// After reset the slot store is swept clear, with busy high.
// The receiver cannot stall; each result shows for exactly one cycle.

module sequence_reorder_buffer_unit
  import sro_pkg::*;
#(
  parameter int WINDOW      = SroWindow,
  parameter int HANDLE_BITS = SroHandleBits
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IW = $clog2(WINDOW);
  localparam int SW = (HANDLE_BITS < HandleW) ? HANDLE_BITS : HandleW;
  localparam int MW = SW + 1;

  state_t            state_r, state_nxt;
  logic [SeqW-1:0]   ne_r, ne_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [IW:0]       cnt_r, cnt_nxt;
  in_item_t          req_r, req_nxt;
  logic [SeqW-1:0]   pend_seq_r, pend_seq_nxt;
  logic [SW-1:0]     pend_h_r, pend_h_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // shared adder
  logic [SeqW-1:0]   op_a, op_b;
  logic [SeqW:0]     sum;

  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [MW-1:0]     mem_wdata, mem_rdata;

  logic [SW-1:0]     req_h;
  logic [SeqW-1:0]   seq_gap;
  logic              is_dup;
  logic [IW:0]       slot_sum;
  logic [IW-1:0]     slot_idx;
  logic [IW-1:0]     head_inc;
  logic              more;

  sro_slot_mem #(
    .DEPTH  (WINDOW),
    .DATA_W (MW)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    if (state_r == S_CHECK) begin
      op_a = req_r.seq_number;
      op_b = ~ne_r;
    end else begin
      op_a = ne_r;
      op_b = '0;
    end
    sum = {1'b0, op_a} + {1'b0, op_b} + (SeqW+1)'(1);
  end

  assign req_h    = req_r.handle[SW-1:0];
  assign seq_gap  = sum[SeqW-1:0];
  assign is_dup   = !sum[SeqW];
  assign slot_sum = (IW+1)'(head_r) + (IW+1)'(seq_gap[IW-1:0]);
  assign slot_idx = (slot_sum >= (IW+1)'(WINDOW)) ? IW'(slot_sum - (IW+1)'(WINDOW))
                                                  : IW'(slot_sum);
  // expected number wrapping to zero restarts the slot index at zero
  assign head_inc = (sum[SeqW-1:0] == '0 || head_r == IW'(WINDOW - 1)) ? '0
                                                                       : head_r + 1'b1;
  // no held entry can outlive a wrap of the expected number
  assign more     = mem_rdata[MW-1] && (cnt_r < (IW+1)'(WINDOW)) && (ne_r != '0);

  always_comb begin
    state_nxt     = state_r;
    ne_nxt        = ne_r;
    head_nxt      = head_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    pend_seq_nxt  = pend_seq_r;
    pend_h_nxt    = pend_h_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = head_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = head_inc;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IW'(WINDOW - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        out_item_nxt.out_handle     = HandleW'(req_h);
        out_item_nxt.out_seq_number = req_r.seq_number;
        out_item_nxt.last           = 1'b1;
        out_item_nxt.status         = ST_DUPLICATE;
        if (is_dup) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (seq_gap == '0) begin
          pend_seq_nxt = req_r.seq_number;
          pend_h_nxt   = req_h;
          cnt_nxt      = (IW+1)'(1);
          state_nxt    = S_ADV;
        end else if (seq_gap >= SeqW'(WINDOW)) begin
          out_item_nxt.status = ST_BEYOND;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          mem_we              = 1'b1;
          mem_waddr           = slot_idx;
          mem_wdata           = {1'b1, req_h};
          out_item_nxt.status = ST_HELD;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      S_ADV: begin
        ne_nxt    = sum[SeqW-1:0];
        head_nxt  = head_inc;
        mem_re    = 1'b1;
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        // read data here belongs to the slot at head_r
        out_valid_nxt               = 1'b1;
        out_item_nxt.out_handle     = HandleW'(pend_h_r);
        out_item_nxt.out_seq_number = pend_seq_r;
        out_item_nxt.status         = ST_DELIVERED;
        out_item_nxt.last           = !more;
        if (more) begin
          pend_seq_nxt = ne_r;
          pend_h_nxt   = mem_rdata[SW-1:0];
          mem_we       = 1'b1;
          ne_nxt       = sum[SeqW-1:0];
          head_nxt     = head_inc;
          mem_re       = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ne_r        <= '0;
      head_r      <= '0;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ne_r        <= ne_nxt;
      head_r      <= head_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    pend_seq_r <= pend_seq_nxt;
    pend_h_r   <= pend_h_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_CHECK || $past(state_r) == S_DRAIN))
    else $error("result strobe without a working state");

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_CHECK))
    else $error("accepted item did not enter check");

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_DELIVERED) |-> out_item.last)
    else $error("non-delivery result not marked last");

  a_idle_holds_expected: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> $stable(ne_r))
    else $error("expected number moved while idle");

endmodule
